// File: rtl/tilt_posture_classifier_top_assert.svh
// Assertion macros for the tilt posture classifier.
// Both sample on the rising edge of clk and stay quiet while rst_n is low.
`ifndef TILT_POSTURE_CLASSIFIER_TOP_ASSERT_SVH
`define TILT_POSTURE_CLASSIFIER_TOP_ASSERT_SVH

// Same-cycle implication.
`define TPC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/tpc_pkg.sv
`default_nettype none

package tpc_pkg;

    localparam int PITCH_W   = 13;
    localparam int TIME_W    = 16;
    localparam int TIMER_W   = 17;
    localparam int ALPHA_W   = 9;
    localparam int BAND_W    = 12;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int POSTURE_W = 2;

    typedef enum logic [POSTURE_W-1:0] {
        ST_STRAIGHT = 2'd0,
        ST_STABLE   = 2'd1,
        ST_WARN     = 2'd2,
        ST_ALARM    = 2'd3
    } posture_t;

    localparam logic [CFG_IDX_W-1:0] REG_FILTER_ALPHA  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STAND_BAND    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WARN_ENTER    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WARN_EXIT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ALARM_ENTER   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ALARM_EXIT    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STAND_HOLD_MS = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ALARM_HOLD_MS = 3'd7;

    localparam logic [ALPHA_W-1:0]        RST_FILTER_ALPHA  = 9'd51;
    localparam logic [BAND_W-1:0]         RST_STAND_BAND    = 12'd32;
    localparam logic signed [PITCH_W-1:0] RST_WARN_ENTER    = 13'sd400;
    localparam logic signed [PITCH_W-1:0] RST_WARN_EXIT     = 13'sd352;
    localparam logic signed [PITCH_W-1:0] RST_ALARM_ENTER   = 13'sd560;
    localparam logic signed [PITCH_W-1:0] RST_ALARM_EXIT    = 13'sd512;
    localparam logic [TIME_W-1:0]         RST_STAND_HOLD_MS = 16'd3000;
    localparam logic [TIME_W-1:0]         RST_ALARM_HOLD_MS = 16'd500;

    // Q1.8 unity weight
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;

    // Hold timer add, saturating at all ones.
    function automatic logic [TIMER_W-1:0] timer_add(input logic [TIMER_W-1:0] t,
                                                     input logic [TIME_W-1:0] d);
        logic [TIMER_W:0] s;
        s = {1'b0, t} + {2'b00, d};
        return s[TIMER_W] ? {TIMER_W{1'b1}} : s[TIMER_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/tilt_posture_classifier_top.sv
//  channel  direction  handshake                    payload
//  in       sink       in_valid / in_stall          pitch_sample, elapsed_ms
//  out      source     out_valid / out_stall        posture, smoothed_pitch
//  cfg      sink       cfg_we (no wait)             cfg_index, cfg_data
//
//  One word per cycle sustained unless out stalls; an accepted word moves from the
//  input register to the result register. The filter multiply and state update are
//  combinational, input register to filter and state registers, which sets the rate.
//  rst_n clears the handshake, filter and state, and loads the register defaults.
//  in_stall rises only while the input register is full and out is stalled.
`default_nettype none

module tilt_posture_classifier_top (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [tpc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [tpc_pkg::CFG_W-1:0]            cfg_data,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic signed [tpc_pkg::PITCH_W-1:0]   pitch_sample,
    input  wire logic [tpc_pkg::TIME_W-1:0]           elapsed_ms,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic [tpc_pkg::POSTURE_W-1:0]             posture,
    output logic signed [tpc_pkg::PITCH_W-1:0]        smoothed_pitch
);

    import tpc_pkg::*;

    // configuration
    logic [ALPHA_W-1:0]        alpha_reg;
    logic [BAND_W-1:0]         band_reg;
    logic signed [PITCH_W-1:0] warn_enter_reg;
    logic signed [PITCH_W-1:0] warn_exit_reg;
    logic signed [PITCH_W-1:0] alarm_enter_reg;
    logic signed [PITCH_W-1:0] alarm_exit_reg;
    logic [TIME_W-1:0]         stand_hold_reg;
    logic [TIME_W-1:0]         alarm_hold_reg;

    // input register
    logic                      in_vld_reg;
    logic signed [PITCH_W-1:0] pitch_reg;
    logic [TIME_W-1:0]         dt_reg;

    // classifier state
    posture_t                  mode_reg, mode_next;
    logic signed [PITCH_W-1:0] filt_reg, filt_next;
    logic                      primed_reg;
    logic [TIMER_W-1:0]        up_time_reg, up_time_next;
    logic [TIMER_W-1:0]        tilt_time_reg, tilt_time_next;

    // result register
    logic                      out_vld_reg;
    posture_t                  posture_reg;
    logic signed [PITCH_W-1:0] smooth_reg;

    logic                      in_take;
    logic                      advance;

    logic [ALPHA_W-1:0]        alpha_eff;
    logic signed [ALPHA_W:0]   alpha_s;
    logic signed [PITCH_W:0]   diff;
    logic signed [23:0]        prod;
    logic signed [23:0]        acc;
    logic signed [PITCH_W:0]   fp_ext;
    logic signed [PITCH_W:0]   band_s;
    logic                      upright;
    logic                      alarm_zone;
    logic                      warn_zone;
    logic                      at_warn_exit;
    logic                      at_alarm_exit;
    logic [TIMER_W-1:0]        up_sum;
    logic [TIMER_W-1:0]        tilt_sum;
    logic                      stand_met;
    logic                      alarm_met;

    assign advance   = in_vld_reg && !(out_vld_reg && out_stall);
    assign in_stall  = in_vld_reg && !advance;
    assign in_take   = in_valid && !in_stall;
    assign out_valid = out_vld_reg;
    assign posture   = posture_reg;
    assign smoothed_pitch = smooth_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg       <= RST_FILTER_ALPHA;
            band_reg        <= RST_STAND_BAND;
            warn_enter_reg  <= RST_WARN_ENTER;
            warn_exit_reg   <= RST_WARN_EXIT;
            alarm_enter_reg <= RST_ALARM_ENTER;
            alarm_exit_reg  <= RST_ALARM_EXIT;
            stand_hold_reg  <= RST_STAND_HOLD_MS;
            alarm_hold_reg  <= RST_ALARM_HOLD_MS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FILTER_ALPHA:  alpha_reg       <= cfg_data[ALPHA_W-1:0];
                REG_STAND_BAND:    band_reg        <= cfg_data[BAND_W-1:0];
                REG_WARN_ENTER:    warn_enter_reg  <= signed'(cfg_data[PITCH_W-1:0]);
                REG_WARN_EXIT:     warn_exit_reg   <= signed'(cfg_data[PITCH_W-1:0]);
                REG_ALARM_ENTER:   alarm_enter_reg <= signed'(cfg_data[PITCH_W-1:0]);
                REG_ALARM_EXIT:    alarm_exit_reg  <= signed'(cfg_data[PITCH_W-1:0]);
                REG_STAND_HOLD_MS: stand_hold_reg  <= cfg_data[TIME_W-1:0];
                REG_ALARM_HOLD_MS: alarm_hold_reg  <= cfg_data[TIME_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            pitch_reg <= pitch_sample;
            dt_reg    <= elapsed_ms;
        end
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= ST_STRAIGHT;
            filt_reg      <= '0;
            primed_reg    <= 1'b0;
            up_time_reg   <= '0;
            tilt_time_reg <= '0;
        end
        else if (advance)
        begin
            mode_reg      <= mode_next;
            filt_reg      <= filt_next;
            primed_reg    <= 1'b1;
            up_time_reg   <= up_time_next;
            tilt_time_reg <= tilt_time_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            posture_reg <= mode_next;
            smooth_reg  <= filt_next;
        end
    end

    // filter: 256*filt + a*(pitch - filt) + 128, floor shift by 8; first sample as is
    always_comb
    begin
        alpha_eff = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
        alpha_s   = signed'({1'b0, alpha_eff});
        diff      = {pitch_reg[PITCH_W-1], pitch_reg} - {filt_reg[PITCH_W-1], filt_reg};
        prod      = 24'(alpha_s) * 24'(diff);
        acc       = {{3{filt_reg[PITCH_W-1]}}, filt_reg, 8'd0} + prod + 24'sd128;
        filt_next = primed_reg ? acc[PITCH_W+7:8] : pitch_reg;
    end

    // zone decode and next state
    always_comb
    begin
        fp_ext        = {filt_next[PITCH_W-1], filt_next};
        band_s        = signed'({2'b00, band_reg});
        upright       = (fp_ext >= -band_s) && (fp_ext <= band_s);
        alarm_zone    = filt_next >= alarm_enter_reg;
        warn_zone     = filt_next >= warn_enter_reg;
        at_warn_exit  = filt_next <= warn_exit_reg;
        at_alarm_exit = filt_next <= alarm_exit_reg;
        up_sum        = timer_add(up_time_reg, dt_reg);
        tilt_sum      = timer_add(tilt_time_reg, dt_reg);
        stand_met     = up_sum >= {1'b0, stand_hold_reg};
        alarm_met     = tilt_sum >= {1'b0, alarm_hold_reg};

        mode_next      = mode_reg;
        up_time_next   = up_time_reg;
        tilt_time_next = tilt_time_reg;

        case (mode_reg)
            ST_STRAIGHT:
            begin
                if (upright && stand_met)
                begin
                    mode_next    = ST_STABLE;
                    up_time_next = '0;
                end
                else
                begin
                    up_time_next = upright ? up_sum : '0;
                    if (alarm_zone)
                    begin
                        if (alarm_met)
                        begin
                            mode_next      = ST_ALARM;
                            tilt_time_next = '0;
                            up_time_next   = '0;
                        end
                        else
                        begin
                            tilt_time_next = tilt_sum;
                        end
                    end
                    else if (warn_zone)
                    begin
                        mode_next      = ST_WARN;
                        tilt_time_next = '0;
                        up_time_next   = '0;
                    end
                    else
                    begin
                        tilt_time_next = '0;
                    end
                end
            end
            ST_STABLE:
            begin
                if (!upright)
                begin
                    if (alarm_zone)
                    begin
                        if (alarm_met)
                        begin
                            mode_next      = ST_ALARM;
                            tilt_time_next = '0;
                        end
                        else
                        begin
                            tilt_time_next = tilt_sum;
                        end
                    end
                    else if (warn_zone)
                    begin
                        mode_next      = ST_WARN;
                        tilt_time_next = '0;
                    end
                    else
                    begin
                        mode_next      = ST_STRAIGHT;
                        tilt_time_next = '0;
                        up_time_next   = '0;
                    end
                end
            end
            ST_WARN:
            begin
                if (alarm_zone && alarm_met)
                begin
                    mode_next      = ST_ALARM;
                    tilt_time_next = '0;
                end
                else
                begin
                    tilt_time_next = alarm_zone ? tilt_sum : '0;
                    if (at_warn_exit)
                    begin
                        mode_next      = ST_STRAIGHT;
                        up_time_next   = '0;
                        tilt_time_next = '0;
                    end
                end
            end
            ST_ALARM:
            begin
                if (at_warn_exit)
                begin
                    mode_next      = ST_STRAIGHT;
                    up_time_next   = '0;
                    tilt_time_next = '0;
                end
                else if (at_alarm_exit)
                begin
                    mode_next      = ST_WARN;
                    tilt_time_next = '0;
                end
            end
            default:
            begin
                mode_next = ST_STRAIGHT;
            end
        endcase
    end

`include "tilt_posture_classifier_top_assert.svh"

    // upright time is cleared on every way out of straight and only counts there
    `TPC_ASSERT_NOW(a_up_time_only_straight, mode_reg != ST_STRAIGHT, up_time_reg == '0, "upright timer nonzero outside straight")
    // alarm is entered with tilt time cleared and never adds to it
    `TPC_ASSERT_NOW(a_tilt_clear_in_alarm, mode_reg == ST_ALARM, tilt_time_reg == '0, "tilt timer nonzero in alarm")
    `TPC_ASSERT_NOW(a_unprimed_idle, !primed_reg, (mode_reg == ST_STRAIGHT) && (filt_reg == '0) && (tilt_time_reg == '0), "state moved before first word")
    `TPC_ASSERT_NEXT(a_advance_fills_out, advance, out_vld_reg && primed_reg, "result register not loaded")
    `TPC_ASSERT_NOW(a_stall_needs_full, in_stall, in_vld_reg && out_vld_reg && out_stall, "input stalled without backpressure")

endmodule

`default_nettype wire

// File: verif/tb_tilt_posture_classifier_top.sv
`timescale 1ns / 100ps

module tb_tilt_posture_classifier_top;

    import tpc_pkg::*;

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_WORDS    = 110;
    localparam int TIMER_CAP      = 131071;

    typedef enum bit { ROW_ITEM, ROW_CFG } row_kind_t;

    typedef struct {
        row_kind_t                kind;
        logic [CFG_IDX_W-1:0]     reg_idx;
        int                       value;
        int                       dt;
        bit                       typed;
        posture_t                 want_posture;
        int                       want_pitch;
    } dir_row_t;

    typedef struct {
        posture_t                 posture;
        logic signed [PITCH_W-1:0] pitch;
    } tilt_result_t;

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_we;
    logic [CFG_IDX_W-1:0]         cfg_index;
    logic [CFG_W-1:0]             cfg_data;
    logic                         in_valid;
    logic                         in_stall;
    logic signed [PITCH_W-1:0]    pitch_sample;
    logic [TIME_W-1:0]            elapsed_ms;
    logic                         out_valid;
    logic                         out_stall;
    logic [POSTURE_W-1:0]         posture;
    logic signed [PITCH_W-1:0]    smoothed_pitch;

    tilt_posture_classifier_top u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .pitch_sample   (pitch_sample),
        .elapsed_ms     (elapsed_ms),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .posture        (posture),
        .smoothed_pitch (smoothed_pitch)
    );

    // classifier shadow: registers
    logic [ALPHA_W-1:0]           alpha_r;
    logic [BAND_W-1:0]            band_r;
    logic signed [PITCH_W-1:0]    warn_in_r;
    logic signed [PITCH_W-1:0]    warn_out_r;
    logic signed [PITCH_W-1:0]    alarm_in_r;
    logic signed [PITCH_W-1:0]    alarm_out_r;
    logic [TIME_W-1:0]            stand_hold_r;
    logic [TIME_W-1:0]            alarm_hold_r;

    // classifier shadow: state
    posture_t                     mode_q;
    logic signed [PITCH_W-1:0]    filt_q;
    bit                           primed;
    logic [TIMER_W-1:0]           upright_ms;
    logic [TIMER_W-1:0]           tilt_ms;

    tilt_result_t                 expected_q [$];
    int                           mismatch_count;
    int                           words_sent;
    int                           results_seen;
    int                           settings_used;
    int                           send_idle_pct;
    int                           recv_idle_pct;
    int                           quiet_cycles;
    bit                           hold_req;

    dir_row_t dir_rows [26] = '{
        '{ROW_ITEM, '0, -4096, 0, 1'b1, ST_STRAIGHT, -4096},   // first sample loads filter
        '{ROW_ITEM, '0, 4095, 65535, 1'b0, ST_STRAIGHT, 0},
        '{ROW_ITEM, '0, 2880, 1, 1'b0, ST_STRAIGHT, 0},
        '{ROW_CFG, REG_FILTER_ALPHA, 256, 0, 1'b0, ST_STRAIGHT, 0},
        '{ROW_ITEM, '0, 0, 65535, 1'b1, ST_STABLE, 0},
        '{ROW_ITEM, '0, 600, 0, 1'b1, ST_STABLE, 600},
        '{ROW_ITEM, '0, 600, 500, 1'b1, ST_ALARM, 600},
        '{ROW_ITEM, '0, 450, 7, 1'b1, ST_WARN, 450},
        '{ROW_ITEM, '0, 300, 7, 1'b1, ST_STRAIGHT, 300},
        '{ROW_ITEM, '0, 450, 0, 1'b1, ST_WARN, 450},
        '{ROW_ITEM, '0, 600, 499, 1'b0, ST_STRAIGHT, 0},
        '{ROW_ITEM, '0, 600, 1, 1'b1, ST_ALARM, 600},
        '{ROW_ITEM, '0, -2880, 3, 1'b1, ST_STRAIGHT, -2880},
        '{ROW_CFG, REG_FILTER_ALPHA, 511, 0, 1'b0, ST_STRAIGHT, 0},  // clamps to unity
        '{ROW_CFG, REG_STAND_HOLD_MS, 0, 0, 1'b0, ST_STRAIGHT, 0},
        '{ROW_CFG, REG_ALARM_HOLD_MS, 0, 0, 1'b0, ST_STRAIGHT, 0},
        '{ROW_ITEM, '0, 16, 0, 1'b1, ST_STABLE, 16},
        '{ROW_ITEM, '0, 600, 0, 1'b1, ST_ALARM, 600},
        '{ROW_ITEM, '0, 0, 0, 1'b1, ST_STRAIGHT, 0},
        '{ROW_ITEM, '0, 600, 0, 1'b1, ST_ALARM, 600},
        '{ROW_CFG, REG_FILTER_ALPHA, 0, 0, 1'b0, ST_STRAIGHT, 0},    // filter frozen
        '{ROW_ITEM, '0, 4095, 65535, 1'b1, ST_ALARM, 600},
        '{ROW_CFG, REG_FILTER_ALPHA, 128, 0, 1'b0, ST_STRAIGHT, 0},
        '{ROW_ITEM, '0, -4096, 43690, 1'b0, ST_STRAIGHT, 0},
        '{ROW_ITEM, '0, 2730, 21845, 1'b0, ST_STRAIGHT, 0},
        '{ROW_ITEM, '0, -2731, 43690, 1'b0, ST_STRAIGHT, 0}
    };

    initial begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic logic [TIMER_W-1:0] hold_add(input logic [TIMER_W-1:0] t,
                                                    input logic [TIME_W-1:0] d);
        int unsigned s;
        s = t + d;
        return (s > TIMER_CAP) ? TIMER_CAP[TIMER_W-1:0] : s[TIMER_W-1:0];
    endfunction

    // Filter update and posture transition for one sample.
    function automatic void classify_sample(input logic signed [PITCH_W-1:0] pitch,
                                            input logic [TIME_W-1:0] dt,
                                            output posture_t p_out,
                                            output logic signed [PITCH_W-1:0] f_out);
        int a;
        int sum;
        int fp;
        int band;
        bit upright;
        bit in_alarm;
        bit in_warn;
        bit done;
        if (!primed) begin
            filt_q = pitch;
            primed = 1'b1;
        end
        else begin
            a = (alpha_r > ALPHA_ONE) ? int'(ALPHA_ONE) : int'(alpha_r);
            sum = a * int'(pitch) + (256 - a) * int'(filt_q) + 128;
            filt_q = PITCH_W'(sum >>> 8);
        end
        fp = filt_q;
        band = band_r;
        upright = (fp >= -band) && (fp <= band);
        in_alarm = fp >= int'(alarm_in_r);
        in_warn = fp >= int'(warn_in_r);
        done = 1'b0;
        case (mode_q)
            ST_STRAIGHT:
            begin
                if (upright) begin
                    upright_ms = hold_add(upright_ms, dt);
                    if (upright_ms >= stand_hold_r) begin
                        mode_q = ST_STABLE;
                        upright_ms = '0;
                        done = 1'b1;
                    end
                end
                else begin
                    upright_ms = '0;
                end
                if (!done) begin
                    if (in_alarm) begin
                        tilt_ms = hold_add(tilt_ms, dt);
                        if (tilt_ms >= alarm_hold_r) begin
                            mode_q = ST_ALARM;
                            tilt_ms = '0;
                            upright_ms = '0;
                        end
                    end
                    else if (in_warn) begin
                        tilt_ms = '0;
                        mode_q = ST_WARN;
                        upright_ms = '0;
                    end
                    else begin
                        tilt_ms = '0;
                    end
                end
            end
            ST_STABLE:
            begin
                if (!upright) begin
                    if (in_alarm) begin
                        tilt_ms = hold_add(tilt_ms, dt);
                        if (tilt_ms >= alarm_hold_r) begin
                            mode_q = ST_ALARM;
                            tilt_ms = '0;
                        end
                    end
                    else if (in_warn) begin
                        tilt_ms = '0;
                        mode_q = ST_WARN;
                    end
                    else begin
                        tilt_ms = '0;
                        mode_q = ST_STRAIGHT;
                        upright_ms = '0;
                    end
                end
            end
            ST_WARN:
            begin
                if (in_alarm) begin
                    tilt_ms = hold_add(tilt_ms, dt);
                    if (tilt_ms >= alarm_hold_r) begin
                        mode_q = ST_ALARM;
                        tilt_ms = '0;
                        done = 1'b1;
                    end
                end
                else begin
                    tilt_ms = '0;
                end
                if (!done && fp <= int'(warn_out_r)) begin
                    mode_q = ST_STRAIGHT;
                    upright_ms = '0;
                    tilt_ms = '0;
                end
            end
            default:
            begin
                if (fp <= int'(warn_out_r)) begin
                    mode_q = ST_STRAIGHT;
                    upright_ms = '0;
                    tilt_ms = '0;
                end
                else if (fp <= int'(alarm_out_r)) begin
                    mode_q = ST_WARN;
                    tilt_ms = '0;
                end
            end
        endcase
        p_out = mode_q;
        f_out = filt_q;
    endfunction

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[CFG_W-1:0];
        case (idx)
            REG_FILTER_ALPHA:  alpha_r = value[ALPHA_W-1:0];
            REG_STAND_BAND:    band_r = value[BAND_W-1:0];
            REG_WARN_ENTER:    warn_in_r = value[PITCH_W-1:0];
            REG_WARN_EXIT:     warn_out_r = value[PITCH_W-1:0];
            REG_ALARM_ENTER:   alarm_in_r = value[PITCH_W-1:0];
            REG_ALARM_EXIT:    alarm_out_r = value[PITCH_W-1:0];
            REG_STAND_HOLD_MS: stand_hold_r = value[TIME_W-1:0];
            default:           alarm_hold_r = value[TIME_W-1:0];
        endcase
        @(negedge clk);
    endtask

    // Entered and left at a falling edge; valid stays up between back-to-back words.
    task automatic send_word(input logic signed [PITCH_W-1:0] pitch,
                             input logic [TIME_W-1:0] dt,
                             input bit typed,
                             input posture_t want_posture,
                             input logic signed [PITCH_W-1:0] want_pitch);
        tilt_result_t r;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        pitch_sample <= pitch;
        elapsed_ms <= dt;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        classify_sample(pitch, dt, r.posture, r.pitch);
        if (typed) begin
            r.posture = want_posture;
            r.pitch = want_pitch;
        end
        expected_q.push_back(r);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    // result checker
    always @(posedge clk) begin
        tilt_result_t want;
        if (rst_n && out_valid && !out_stall) begin
            results_seen++;
            if (expected_q.size() == 0) begin
                $display("%0t unexpected word: posture %0d pitch %0d",
                         $time, posture, smoothed_pitch);
                mismatch_count++;
            end
            else begin
                want = expected_q.pop_front();
                if (posture !== want.posture) begin
                    $display("%0t posture: expected %0d got %0d",
                             $time, want.posture, posture);
                    mismatch_count++;
                end
                if (smoothed_pitch !== want.pitch) begin
                    $display("%0t smoothed_pitch: expected %0d got %0d",
                             $time, want.pitch, smoothed_pitch);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t watchdog: no handshake for %0d cycles, %0d words pending",
                     $time, quiet_cycles, expected_q.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // output stall; a hold-off request parks the output for a long stretch
    initial begin
        int hold_left;
        hold_left = 0;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    initial begin
        int v_alpha;
        int v_band;
        int v_wen;
        int v_wex;
        int v_aen;
        int v_aex;
        int v_sh;
        int v_ah;
        int run_left;
        int target;
        int spread;
        int pv;
        int dv;
        int r;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        pitch_sample = '0;
        elapsed_ms = '0;
        hold_req = 1'b0;
        mismatch_count = 0;
        words_sent = 0;
        results_seen = 0;
        settings_used = 1;
        quiet_cycles = 0;
        send_idle_pct = 11;
        recv_idle_pct = 45;
        run_left = 0;
        target = 0;
        spread = 0;

        alpha_r = RST_FILTER_ALPHA;
        band_r = RST_STAND_BAND;
        warn_in_r = RST_WARN_ENTER;
        warn_out_r = RST_WARN_EXIT;
        alarm_in_r = RST_ALARM_ENTER;
        alarm_out_r = RST_ALARM_EXIT;
        stand_hold_r = RST_STAND_HOLD_MS;
        alarm_hold_r = RST_ALARM_HOLD_MS;
        mode_q = ST_STRAIGHT;
        filt_q = '0;
        primed = 1'b0;
        upright_ms = '0;
        tilt_ms = '0;

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                wait_drained();
                cfg_write(dir_rows[i].reg_idx, dir_rows[i].value);
                cfg_we <= 1'b0;
                settings_used++;
            end
            else begin
                send_word(dir_rows[i].value[PITCH_W-1:0], dir_rows[i].dt[TIME_W-1:0],
                          dir_rows[i].typed, dir_rows[i].want_posture,
                          dir_rows[i].want_pitch[PITCH_W-1:0]);
            end
        end

        for (int m = 0; m < 3; m++) begin
            send_idle_pct = (m == 0) ? 11 : (m == 1) ? 45 : 0;
            recv_idle_pct = (m == 0) ? 45 : (m == 1) ? 11 : 0;
            for (int p = 0; p < 5; p++) begin
                wait_drained();
                case (p)
                    0:
                    begin
                        v_alpha = RST_FILTER_ALPHA;
                        v_band = RST_STAND_BAND;
                        v_wen = RST_WARN_ENTER;
                        v_wex = RST_WARN_EXIT;
                        v_aen = RST_ALARM_ENTER;
                        v_aex = RST_ALARM_EXIT;
                        v_sh = RST_STAND_HOLD_MS;
                        v_ah = RST_ALARM_HOLD_MS;
                    end
                    3:
                    begin
                        r = $urandom_range(2);
                        v_alpha = (r == 0) ? 0 : (r == 1) ? 256 : 511;
                        v_band = $urandom_range(1) ? 4095 : 0;
                        v_wen = $urandom_range(1) ? 4095 : -4096;
                        v_wex = $urandom_range(1) ? 4095 : -4096;
                        v_aen = $urandom_range(1) ? 4095 : -4096;
                        v_aex = $urandom_range(1) ? 4095 : -4096;
                        v_sh = $urandom_range(1) ? 65535 : 0;
                        v_ah = $urandom_range(1) ? 65535 : 0;
                    end
                    4:
                    begin
                        // thresholds in any order
                        v_alpha = $urandom_range(511);
                        v_band = $urandom_range(4095);
                        v_wen = int'($urandom_range(8191)) - 4096;
                        v_wex = int'($urandom_range(8191)) - 4096;
                        v_aen = int'($urandom_range(8191)) - 4096;
                        v_aex = int'($urandom_range(8191)) - 4096;
                        v_sh = $urandom_range(65535);
                        v_ah = $urandom_range(65535);
                    end
                    default:
                    begin
                        v_alpha = $urandom_range(256, 16);
                        v_band = $urandom_range(200);
                        v_wex = int'($urandom_range(700)) - 100;
                        v_wen = v_wex + int'($urandom_range(150));
                        v_aex = v_wen + int'($urandom_range(200));
                        v_aen = v_aex + int'($urandom_range(150));
                        v_sh = $urandom_range(3000);
                        v_ah = $urandom_range(1500);
                    end
                endcase
                cfg_write(REG_FILTER_ALPHA, v_alpha);
                cfg_write(REG_STAND_BAND, v_band);
                cfg_write(REG_WARN_ENTER, v_wen);
                cfg_write(REG_WARN_EXIT, v_wex);
                cfg_write(REG_ALARM_ENTER, v_aen);
                cfg_write(REG_ALARM_EXIT, v_aex);
                cfg_write(REG_STAND_HOLD_MS, v_sh);
                cfg_write(REG_ALARM_HOLD_MS, v_ah);
                cfg_we <= 1'b0;
                settings_used++;
                if (m == 2 && p == 0)
                    hold_req = 1'b1;

                // dwell near a threshold, zero or a random pitch for a while, with the odd wild sample
                for (int k = 0; k < PHASE_WORDS; k++) begin
                    if (run_left == 0) begin
                        run_left = $urandom_range(40, 1);
                        spread = $urandom_range(48);
                        case ($urandom_range(7))
                            0:       target = 0;
                            1:       target = band_r;
                            2:       target = -int'(band_r);
                            3:       target = warn_in_r;
                            4:       target = warn_out_r;
                            5:       target = alarm_in_r;
                            6:       target = alarm_out_r;
                            default: target = int'($urandom_range(5760)) - 2880;
                        endcase
                    end
                    run_left--;
                    if ($urandom_range(99) < 5) begin
                        pv = int'($urandom_range(8191)) - 4096;
                    end
                    else begin
                        pv = target + int'($urandom_range(2 * spread)) - spread;
                        if (pv > 4095)
                            pv = 4095;
                        if (pv < -4096)
                            pv = -4096;
                    end
                    r = $urandom_range(99);
                    if (r < 60)
                        dv = $urandom_range(250);
                    else if (r < 85)
                        dv = $urandom_range(2000);
                    else if (r < 95)
                        dv = $urandom_range(65535);
                    else
                        dv = $urandom_range(1) ? 65535 : 0;
                    send_word(pv[PITCH_W-1:0], dv[TIME_W-1:0], 1'b0, ST_STRAIGHT, '0);
                end
            end
        end

        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        $display("covered %0d pitch samples under %0d register settings, %0d results checked",
                 words_sent, settings_used, results_seen);
        $display("sender and receiver idling mixed, plus one long output hold-off");
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/tpc_pkg.sv
rtl/tilt_posture_classifier_top.sv
verif/tb_tilt_posture_classifier_top.sv
